FILE: rtl/tfn_pkg.sv
package tfn_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int NUM_LANES = 3;

    // per component flags that travel beside the data
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } tfn_ctl_t;

endpackage

FILE: rtl/tfn_front.sv
module tfn_front #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    output logic [2*(2*COORD_WIDTH+1)+1:0] sum_sq,
    output logic [2*(2*COORD_WIDTH+1)-1:0] sq [tfn_pkg::NUM_LANES],
    output tfn_pkg::tfn_ctl_t              ctl [tfn_pkg::NUM_LANES]
);

    localparam int EW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * EW;
    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int WW  = MW + 1;
    localparam int LW  = (MW + 1) / 2;
    localparam int HW  = MW - LW;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int NL  = tfn_pkg::NUM_LANES;

    logic [5:0] v_reg;

    logic signed [EW-1:0] u_reg [NL];
    logic signed [EW-1:0] e_reg [NL];
    logic signed [PW-1:0] pa_reg [NL];
    logic signed [PW-1:0] pb_reg [NL];
    logic [MW-1:0]        mag_reg [NL];
    logic [NL-1:0]        neg_c_reg, neg_d_reg, neg_e_reg, neg_f_reg;
    logic [2*HW-1:0]      hh_reg [NL];
    logic [HW+LW-1:0]     hl_reg [NL];
    logic [2*LW-1:0]      ll_reg [NL];
    logic [SQW-1:0]       sqe_reg [NL];
    logic [SQW-1:0]       sqf_reg [NL];
    logic [SW-1:0]        s_reg;
    logic                 zero_reg;

    logic signed [WW-1:0] w_next [NL];
    logic [WW-1:0]        wm_next [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            w_next[i]  = WW'(pa_reg[i]) - WW'(pb_reg[i]);
            wm_next[i] = w_next[i][WW-1] ? WW'(-w_next[i]) : WW'(w_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edges a-b and b-c
            u_reg[0] <= EW'(ax) - EW'(bx);
            u_reg[1] <= EW'(ay) - EW'(by);
            u_reg[2] <= EW'(az) - EW'(bz);
            e_reg[0] <= EW'(bx) - EW'(cx);
            e_reg[1] <= EW'(by) - EW'(cy);
            e_reg[2] <= EW'(bz) - EW'(cz);

            pa_reg[0] <= u_reg[1] * e_reg[2];
            pb_reg[0] <= u_reg[2] * e_reg[1];
            pa_reg[1] <= u_reg[2] * e_reg[0];
            pb_reg[1] <= u_reg[0] * e_reg[2];
            pa_reg[2] <= u_reg[0] * e_reg[1];
            pb_reg[2] <= u_reg[1] * e_reg[0];

            for (int i = 0; i < NL; i++)
            begin
                mag_reg[i]   <= wm_next[i][MW-1:0];
                neg_c_reg[i] <= w_next[i][WW-1];

                // square split into half width partial products
                hh_reg[i] <= (2*HW)'(mag_reg[i][MW-1:LW]) * (2*HW)'(mag_reg[i][MW-1:LW]);
                hl_reg[i] <= (HW+LW)'(mag_reg[i][MW-1:LW]) * (HW+LW)'(mag_reg[i][LW-1:0]);
                ll_reg[i] <= (2*LW)'(mag_reg[i][LW-1:0]) * (2*LW)'(mag_reg[i][LW-1:0]);
                neg_d_reg[i] <= neg_c_reg[i];

                sqe_reg[i] <= (SQW'(hh_reg[i]) << (2*LW)) + (SQW'(hl_reg[i]) << (LW+1))
                            + SQW'(ll_reg[i]);
                neg_e_reg[i] <= neg_d_reg[i];

                sqf_reg[i] <= sqe_reg[i];
                neg_f_reg[i] <= neg_e_reg[i];
            end
            s_reg    <= SW'(sqe_reg[0]) + SW'(sqe_reg[1]) + SW'(sqe_reg[2]);
            zero_reg <= (sqe_reg[0] == '0) && (sqe_reg[1] == '0) && (sqe_reg[2] == '0);
        end
    end

    assign sum_sq = s_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            sq[i]        = sqf_reg[i];
            ctl[i].valid = v_reg[5];
            ctl[i].neg   = neg_f_reg[i];
            ctl[i].zero  = zero_reg;
        end
    end

endmodule

FILE: rtl/tfn_lane.sv
module tfn_lane #(
    parameter int COORD_WIDTH   = tfn_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = tfn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic [2*(2*COORD_WIDTH+1)+1:0]   sum_sq,
    input  logic [2*(2*COORD_WIDTH+1)-1:0]   sq,
    input  tfn_pkg::tfn_ctl_t                ctl_in,
    output logic [OUT_FRAC_BITS+1:0]         q,
    output tfn_pkg::tfn_ctl_t                ctl_out
);

    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int QW  = OUT_FRAC_BITS + 2;
    localparam int NST = QW;
    localparam int TW  = SW + 2 * OUT_FRAC_BITS + 4;

    // remainder num - q^2*S and running q*S, one quotient bit per stage
    logic [TW-1:0]     rem_reg [NST];
    logic [TW-1:0]     qs_reg  [NST];
    logic [QW-1:0]     q_reg   [NST];
    logic [TW-1:0]     s_reg   [NST];
    tfn_pkg::tfn_ctl_t ctl_reg [NST];

    logic [TW-1:0]     rem_in [NST];
    logic [TW-1:0]     qs_in  [NST];
    logic [QW-1:0]     q_in   [NST];
    logic [TW-1:0]     s_in   [NST];
    tfn_pkg::tfn_ctl_t ctl_i  [NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            localparam int B = NST - 1 - k;
            logic [TW-1:0] trial;
            logic          take;

            if (k == 0)
            begin : g_first
                assign rem_in[k] = TW'(sq) << (2 * OUT_FRAC_BITS);
                assign qs_in[k]  = '0;
                assign q_in[k]   = '0;
                assign s_in[k]   = TW'(sum_sq);
                assign ctl_i[k]  = ctl_in;
            end
            else
            begin : g_next
                assign rem_in[k] = rem_reg[k-1];
                assign qs_in[k]  = qs_reg[k-1];
                assign q_in[k]   = q_reg[k-1];
                assign s_in[k]   = s_reg[k-1];
                assign ctl_i[k]  = ctl_reg[k-1];
            end

            assign trial = (qs_in[k] << (B + 1)) + (s_in[k] << (2 * B));
            assign take  = (trial <= rem_in[k]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[k] <= '0;
                end
                else if (en)
                begin
                    ctl_reg[k] <= ctl_i[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_reg[k] <= s_in[k];
                    if (take)
                    begin
                        rem_reg[k] <= rem_in[k] - trial;
                        qs_reg[k]  <= qs_in[k] + (s_in[k] << B);
                        q_reg[k]   <= q_in[k] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k] <= rem_in[k];
                        qs_reg[k]  <= qs_in[k];
                        q_reg[k]   <= q_in[k];
                    end
                end
            end
        end
    endgenerate

    assign q       = q_reg[NST-1];
    assign ctl_out = ctl_reg[NST-1];

endmodule

FILE: rtl/tfn_merge.sv
module tfn_merge #(
    parameter int OUT_FRAC_BITS = tfn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [OUT_FRAC_BITS+1:0]        q [tfn_pkg::NUM_LANES],
    input  tfn_pkg::tfn_ctl_t               ctl [tfn_pkg::NUM_LANES],
    output logic                            valid,
    output logic signed [OUT_FRAC_BITS+1:0] nx,
    output logic signed [OUT_FRAC_BITS+1:0] ny,
    output logic signed [OUT_FRAC_BITS+1:0] nz
);

    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int NL = tfn_pkg::NUM_LANES;

    logic          valid_reg;
    logic [OW-1:0] n_reg  [NL];
    logic [OW-1:0] n_next [NL];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (ctl[i].zero)
            begin
                n_next[i] = '0;
            end
            else if (ctl[i].neg)
            begin
                n_next[i] = OW'(-q[i]);
            end
            else
            begin
                n_next[i] = q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                n_reg[i] <= n_next[i];
            end
        end
    end

    assign valid = valid_reg;
    assign nx    = n_reg[0];
    assign ny    = n_reg[1];
    assign nz    = n_reg[2];

endmodule

FILE: rtl/triangle_face_normal.sv
// Unit face normal of a triangle: edges a-b and b-c are crossed and each component of the
// cross product is divided by its length, truncated toward zero, into signed Q1.14 (a
// degenerate triangle gives all zeros). One triangle is taken every clock while the output is not
// stalled. The pipeline has six front stages for edges, cross product and sum of squares, one
// stage per quotient bit in each of the three normalising lanes, which find sqrt-free
// quotient bits by shift-and-subtract, and one output register. A stall on a valid output
// freezes the whole pipeline and is passed to in_stall in the same cycle.
module triangle_face_normal #(
    parameter int COORD_WIDTH   = tfn_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = tfn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_WIDTH-1:0]   ax,
    input  logic signed [COORD_WIDTH-1:0]   ay,
    input  logic signed [COORD_WIDTH-1:0]   az,
    input  logic signed [COORD_WIDTH-1:0]   bx,
    input  logic signed [COORD_WIDTH-1:0]   by,
    input  logic signed [COORD_WIDTH-1:0]   bz,
    input  logic signed [COORD_WIDTH-1:0]   cx,
    input  logic signed [COORD_WIDTH-1:0]   cy,
    input  logic signed [COORD_WIDTH-1:0]   cz,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [OUT_FRAC_BITS+1:0] nx,
    output logic signed [OUT_FRAC_BITS+1:0] ny,
    output logic signed [OUT_FRAC_BITS+1:0] nz
);

    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int QW  = OUT_FRAC_BITS + 2;
    localparam int NL  = tfn_pkg::NUM_LANES;

    logic              en;
    logic [SW-1:0]     sum_sq;
    logic [SQW-1:0]    sq [NL];
    tfn_pkg::tfn_ctl_t front_ctl [NL];
    logic [QW-1:0]     lane_q [NL];
    tfn_pkg::tfn_ctl_t lane_ctl [NL];

    assign en       = ~(out_valid & out_stall);
    assign in_stall = ~en;

    tfn_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_valid(in_valid),
        .ax      (ax),
        .ay      (ay),
        .az      (az),
        .bx      (bx),
        .by      (by),
        .bz      (bz),
        .cx      (cx),
        .cy      (cy),
        .cz      (cz),
        .sum_sq  (sum_sq),
        .sq      (sq),
        .ctl     (front_ctl)
    );

    genvar i;
    generate
        for (i = 0; i < NL; i++)
        begin : g_lane
            tfn_lane #(
                .COORD_WIDTH  (COORD_WIDTH),
                .OUT_FRAC_BITS(OUT_FRAC_BITS)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .en     (en),
                .sum_sq (sum_sq),
                .sq     (sq[i]),
                .ctl_in (front_ctl[i]),
                .q      (lane_q[i]),
                .ctl_out(lane_ctl[i])
            );
        end
    endgenerate

    tfn_merge #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_merge (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .q    (lane_q),
        .ctl  (lane_ctl),
        .valid(out_valid),
        .nx   (nx),
        .ny   (ny),
        .nz   (nz)
    );

    localparam logic signed [QW-1:0] ONE = QW'(1) << OUT_FRAC_BITS;

    // a full length component leaves nothing for the others
    a_axis_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (nx == ONE || nx == -ONE) |-> ny == '0 && nz == '0)
        else $error("axis normal x with nonzero y or z");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nx >= -ONE && nx <= ONE && ny >= -ONE && ny <= ONE
                      && nz >= -ONE && nz <= ONE)
        else $error("normal component beyond unit range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz))
        else $error("stalled result item changed");

endmodule

FILE: bench/triangle_face_normal_checker.sv
module triangle_face_normal_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] az,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic signed [15:0] bz,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] cy,
    input  logic signed [15:0] cz,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] nx,
    input  logic signed [15:0] ny,
    input  logic signed [15:0] nz,
    output int                 fails,
    output int                 pending
);

    localparam int FRAC = tfn_pkg::OUT_FRAC_BITS_DEF;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } normal_t;

    normal_t normal_q[$];

    // largest q with q^2 * sumsq <= w^2 * 2^(2*frac), then signed as w
    function automatic logic [15:0] unit_comp(logic signed [63:0] w, logic [127:0] sumsq);
        logic [127:0] mag;
        logic [127:0] num;
        logic [127:0] cand;
        logic [127:0] q;
        q = '0;
        if (sumsq == 0)
        begin
            return '0;
        end
        mag = (w < 0) ? 128'(-w) : 128'(w);
        num = (mag * mag) << (2 * FRAC);
        for (int b = FRAC + 1; b >= 0; b--)
        begin
            cand = q | (128'd1 << b);
            if (cand * cand * sumsq <= num)
            begin
                q = cand;
            end
        end
        if (w < 0)
        begin
            q = -q;
        end
        return q[15:0];
    endfunction

    function automatic normal_t face_normal(logic signed [15:0] pax, logic signed [15:0] pay,
        logic signed [15:0] paz, logic signed [15:0] pbx, logic signed [15:0] pby,
        logic signed [15:0] pbz, logic signed [15:0] pcx, logic signed [15:0] pcy,
        logic signed [15:0] pcz);
        logic signed [63:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
        logic [127:0] mx, my, mz;
        logic [127:0] sumsq;
        normal_t r;
        ux = 64'(pax) - 64'(pbx);
        uy = 64'(pay) - 64'(pby);
        uz = 64'(paz) - 64'(pbz);
        vx = 64'(pbx) - 64'(pcx);
        vy = 64'(pby) - 64'(pcy);
        vz = 64'(pbz) - 64'(pcz);
        wx = uy * vz - uz * vy;
        wy = uz * vx - ux * vz;
        wz = ux * vy - uy * vx;
        // squares need more than 64 bits
        mx = (wx < 0) ? 128'(-wx) : 128'(wx);
        my = (wy < 0) ? 128'(-wy) : 128'(wy);
        mz = (wz < 0) ? 128'(-wz) : 128'(wz);
        sumsq = mx * mx + my * my + mz * mz;
        r.x = unit_comp(wx, sumsq);
        r.y = unit_comp(wy, sumsq);
        r.z = unit_comp(wz, sumsq);
        return r;
    endfunction

    assign pending = normal_q.size();

    initial
    begin
        fails = 0;
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                normal_q = {normal_q, face_normal(ax, ay, az, bx, by, bz, cx, cy, cz)};
            end
            if (out_valid && !out_stall)
            begin
                if (normal_q.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("unexpected item: nx=%0d ny=%0d nz=%0d", nx, ny, nz);
                    end
                    fails = fails + 1;
                end
                else
                begin
                    want = normal_q.pop_front();
                    if (want.x !== nx || want.y !== ny || want.z !== nz)
                    begin
                        if (fails < 10)
                        begin
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                $signed(want.x), $signed(want.y), $signed(want.z),
                                nx, ny, nz);
                        end
                        fails = fails + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/triangle_face_normal_tb.sv
module triangle_face_normal_tb;

    localparam int WATCHDOG = 5000;
    localparam int HOLD_OFF = 300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] nx, ny, nz;
    int fails;
    int pending;
    int tx_idle;
    int rx_idle;
    logic hold_req;
    int idle_cycles;

    triangle_face_normal dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .cx(cx), .cy(cy), .cz(cz),
        .out_valid(out_valid), .out_stall(out_stall),
        .nx(nx), .ny(ny), .nz(nz)
    );

    triangle_face_normal_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .cx(cx), .cy(cy), .cz(cz),
        .out_valid(out_valid), .out_stall(out_stall),
        .nx(nx), .ny(ny), .nz(nz),
        .fails(fails), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_triangle(logic [15:0] pax, logic [15:0] pay, logic [15:0] paz,
        logic [15:0] pbx, logic [15:0] pby, logic [15:0] pbz,
        logic [15:0] pcx, logic [15:0] pcy, logic [15:0] pcz);
        logic taken;
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            ax <= 16'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ax <= pax; ay <= pay; az <= paz;
        bx <= pbx; by <= pby; bz <= pbz;
        cx <= pcx; cy <= pcy; cz <= pcz;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // mostly small, nearby vertices, with some full range, flat and collinear ones
    task automatic send_random();
        logic [15:0] p[9];
        int kind;
        int span;
        kind = $urandom_range(9);
        span = 1 << $urandom_range(2, 15);
        foreach (p[i])
        begin
            p[i] = (kind < 3) ? 16'($urandom) : 16'($urandom_range(span - 1) - span / 2);
        end
        if (kind == 6)
        begin
            p[2] = p[5];
            p[8] = p[5];
        end
        else if (kind == 7)
        begin
            p[6] = p[3] + (p[3] - p[0]);
            p[7] = p[4] + (p[4] - p[1]);
            p[8] = p[5] + (p[5] - p[2]);
        end
        else if (kind == 8)
        begin
            p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
        end
        send_triangle(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    endtask

    // receiver: random stalls, and one long hold-off when the request rises
    initial
    begin
        int hold_cnt;
        logic hold_seen;
        hold_cnt = 0;
        hold_seen = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_cnt = HOLD_OFF;
            end
            hold_seen = hold_req;
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt = hold_cnt - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        hold_req = 1'b0;
        ax = '0; ay = '0; az = '0; bx = '0; by = '0; bz = '0; cx = '0; cy = '0; cz = '0;
        tx_idle = 27;
        rx_idle = 60;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate: coincident and collinear
        send_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_triangle(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
            16'h7fff, 16'h8000, 16'h7fff);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256,
            16'd512, 16'd512, 16'd512);
        // axis aligned, both signs
        send_triangle(16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd256, 16'd0);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd256, 16'd0);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd256);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd256);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd0, 16'd256);
        send_triangle(16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256);
        // extremes of the coordinates
        send_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h8000, 16'h7fff);
        send_triangle(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            16'h8000, 16'h8000, 16'h7fff);
        send_triangle(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff);
        send_triangle(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0000, 16'hffff,
            16'h0000, 16'h0001, 16'h0001);
        send_triangle(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd1, 16'd1);
        send_triangle(16'h8000, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0,
            16'd0, 16'd0, 16'h8000);
        send_triangle(16'h7fff, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0,
            16'd0, 16'd0, 16'h7fff);

        repeat (260) send_random();

        // long hold-off while items keep coming, so the pipeline fills
        hold_req = 1'b1;
        repeat (40) send_random();
        hold_req = 1'b0;

        tx_idle = 60;
        rx_idle = 27;
        repeat (250) send_random();

        tx_idle = 0;
        rx_idle = 0;
        repeat (250) send_random();
        in_valid <= 1'b0;

        while (pending > 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (fails == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
